// File: rtl/csv_fixed_schema_row_parser_assert.svh
// Assertion helpers for the row parser. The clock is clock and the reset is reset.
`ifndef CSV_FIXED_SCHEMA_ROW_PARSER_ASSERT_SVH
`define CSV_FIXED_SCHEMA_ROW_PARSER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSVP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CSVP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/csvp_pkg.sv
package csvp_pkg;

   localparam int unsigned HDR_LEN = 46;
   localparam logic [8*HDR_LEN-1:0] HDR_TEXT =
      "date,time,area,residence,age,gender,population";
   localparam logic [511:0] HDR_ROM = {HDR_TEXT, {(512 - 8*HDR_LEN){1'b0}}};
   localparam logic [5:0] HDR_END = 6'(HDR_LEN);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_FF      = 8'h0C;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   localparam logic [2:0] FIELD_DATE       = 3'd0;
   localparam logic [2:0] FIELD_TIME       = 3'd1;
   localparam logic [2:0] FIELD_AREA       = 3'd2;
   localparam logic [2:0] FIELD_RESIDENCE  = 3'd3;
   localparam logic [2:0] FIELD_AGE        = 3'd4;
   localparam logic [2:0] FIELD_GENDER     = 3'd5;
   localparam logic [2:0] FIELD_POPULATION = 3'd6;

   localparam logic [63:0] LIM_DATE = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] LIM_TIME = 64'h0000_0000_0000_FFFF;
   localparam logic [63:0] LIM_AREA = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LIM_POS  = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] LIM_NEG  = 64'h0000_0000_8000_0000;

   localparam logic [63:0] QUOT_DATE = LIM_DATE / 64'd10;
   localparam logic [63:0] QUOT_TIME = LIM_TIME / 64'd10;
   localparam logic [63:0] QUOT_AREA = LIM_AREA / 64'd10;
   localparam logic [63:0] QUOT_POS  = LIM_POS / 64'd10;
   localparam logic [63:0] QUOT_NEG  = LIM_NEG / 64'd10;
   localparam logic [3:0]  REM_DATE  = 4'(LIM_DATE % 64'd10);
   localparam logic [3:0]  REM_TIME  = 4'(LIM_TIME % 64'd10);
   localparam logic [3:0]  REM_AREA  = 4'(LIM_AREA % 64'd10);
   localparam logic [3:0]  REM_POS   = 4'(LIM_POS % 64'd10);
   localparam logic [3:0]  REM_NEG   = 4'(LIM_NEG % 64'd10);

   typedef enum logic [1:0] {
      STATUS_ROW_OK          = 2'd0,
      STATUS_ROW_ERROR       = 2'd1,
      STATUS_HEADER_OK       = 2'd2,
      STATUS_HEADER_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_BLANKS = 2'd0,
      PHASE_SIGN   = 2'd1,
      PHASE_DIGITS = 2'd2
   } phase_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        date;
      logic [15:0]        time_res;
      logic [63:0]        area;
      logic signed [31:0] residence;
      logic signed [31:0] age;
      logic signed [31:0] gender;
      logic signed [31:0] population;
      logic [31:0]        line_index;
   } result_type;

   function automatic logic [7:0] hdr_char(input logic [5:0] pos);
      hdr_char = HDR_ROM[{~pos, 3'b000} +: 8];
   endfunction

   function automatic logic [63:0] limit_quot(input logic [2:0] idx, input logic neg);
      case (idx)
         FIELD_DATE: limit_quot = QUOT_DATE;
         FIELD_TIME: limit_quot = QUOT_TIME;
         FIELD_AREA: limit_quot = QUOT_AREA;
         default:    limit_quot = neg ? QUOT_NEG : QUOT_POS;
      endcase
   endfunction

   function automatic logic [3:0] limit_rem(input logic [2:0] idx, input logic neg);
      case (idx)
         FIELD_DATE: limit_rem = REM_DATE;
         FIELD_TIME: limit_rem = REM_TIME;
         FIELD_AREA: limit_rem = REM_AREA;
         default:    limit_rem = neg ? REM_NEG : REM_POS;
      endcase
   endfunction

endpackage

// File: rtl/csvp_if.sv
interface csvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface csvp_rsp_if;
   logic                 valid;
   logic                 ready;
   csvp_pkg::status_type status;
   logic [31:0]          date;
   logic [15:0]          time_res;
   logic [63:0]          area;
   logic signed [31:0]   residence;
   logic signed [31:0]   age;
   logic signed [31:0]   gender;
   logic signed [31:0]   population;
   logic [31:0]          line_index;

   modport source (output valid, output status, output date, output time_res,
                   output area, output residence, output age, output gender,
                   output population, output line_index, input ready);
   modport sink (input valid, input status, input date, input time_res,
                 input area, input residence, input age, input gender,
                 input population, input line_index, output ready);
endinterface

// File: rtl/csv_fixed_schema_row_parser.sv
// Fixed-schema CSV row parser.
// req_bus carries one text byte per beat, or an end-of-input marker that
// closes a partial line. The first line must match the fixed header text;
// each later line yields one rsp_bus beat with the seven decoded fields, a
// status code and the running line number. Bytes that do not end a line
// produce no response beat.
// A request beat lands in an input register; when that beat is processed, the
// parser state and the response register are updated, so a line's response
// is registered in the input register and then in the response register.
// Throughput is one byte per cycle while rsp_bus does not stall; the limit is
// the combinational multiply-by-ten accumulate and overflow compare on the 64-bit accumulator.
// When rsp_bus stalls, the response register holds its beat and the input
// register still takes one more request beat if it is empty; after that req_bus.ready drops
// until the response is taken.
// A synchronous reset empties both registers, clears the line counter and
// returns the parser to expecting the header line.
module csv_fixed_schema_row_parser (
   input logic        clock,
   input logic        reset,
   csvp_req_if.sink   req_bus,
   csvp_rsp_if.source rsp_bus
);
   import csvp_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   logic        header_done_ff, header_done_in;
   logic [5:0]  header_pos_ff, header_pos_in;
   logic        header_bad_ff, header_bad_in;
   logic [31:0] line_count_ff, line_count_in;
   logic [2:0]  field_index_ff, field_index_in;
   phase_type   field_phase_ff, field_phase_in;
   logic        negative_ff, negative_in;
   logic [63:0] acc_ff, acc_in;
   logic        row_bad_ff, row_bad_in;
   logic        line_started_ff, line_started_in;
   logic [31:0] held_date_ff, held_date_in;
   logic [15:0] held_time_ff, held_time_in;
   logic [63:0] held_area_ff, held_area_in;
   logic [31:0] held_signed_ff [3];
   logic [31:0] held_signed_in [3];

   logic        advance;
   logic        process;
   logic        line_end;
   logic        emit;
   logic        is_digit;
   logic        is_blank;
   logic [3:0]  digit;
   logic [31:0] signed_val;
   logic [63:0] quot;
   logic [3:0]  rem;
   logic        overflow;
   logic [63:0] acc_step;
   logic        row_ok;
   logic        fail_beat;
   logic        values_zero;
   logic [31:0] count_next;
   logic        index_ok;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign process       = in_valid_ff && advance;

   assign line_end = in_end_ff ? line_started_ff : (in_byte_ff == CHAR_NEWLINE);
   assign emit     = process && line_end;

   assign is_digit   = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign is_blank   = (in_byte_ff == CHAR_SPACE) || (in_byte_ff == CHAR_TAB) ||
                       (in_byte_ff == CHAR_VTAB) || (in_byte_ff == CHAR_FF) ||
                       (in_byte_ff == CHAR_CR);
   assign digit      = in_byte_ff[3:0];
   assign signed_val = negative_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   assign quot       = limit_quot(field_index_ff, negative_ff);
   assign rem        = limit_rem(field_index_ff, negative_ff);
   assign overflow   = (acc_ff > quot) || ((acc_ff == quot) && (digit > rem));
   assign acc_step   = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} + {60'd0, digit};
   assign row_ok     = !row_bad_ff && (field_phase_ff == PHASE_DIGITS) &&
                       (field_index_ff == FIELD_POPULATION);

   always_comb begin
      header_done_in  = header_done_ff;
      header_pos_in   = header_pos_ff;
      header_bad_in   = header_bad_ff;
      line_count_in   = line_count_ff;
      field_index_in  = field_index_ff;
      field_phase_in  = field_phase_ff;
      negative_in     = negative_ff;
      acc_in          = acc_ff;
      row_bad_in      = row_bad_ff;
      line_started_in = line_started_ff;
      held_date_in    = held_date_ff;
      held_time_in    = held_time_ff;
      held_area_in    = held_area_ff;
      held_signed_in  = held_signed_ff;
      if (line_end) begin
         line_count_in   = line_count_ff + 32'd1;
         line_started_in = 1'b0;
         if (!header_done_ff) begin
            header_done_in = (header_pos_ff == HDR_END) && !header_bad_ff;
            header_pos_in  = '0;
            header_bad_in  = 1'b0;
         end else begin
            field_index_in = FIELD_DATE;
            field_phase_in = PHASE_BLANKS;
            negative_in    = 1'b0;
            acc_in         = '0;
            row_bad_in     = 1'b0;
         end
      end else if (!in_end_ff) begin
         line_started_in = 1'b1;
         if (!header_done_ff) begin
            if ((header_pos_ff < HDR_END) && (in_byte_ff == hdr_char(header_pos_ff))) begin
               header_pos_in = header_pos_ff + 6'd1;
            end else begin
               header_bad_in = 1'b1;
            end
         end else if (in_byte_ff == CHAR_COMMA) begin
            if (field_phase_ff == PHASE_DIGITS) begin
               case (field_index_ff)
                  FIELD_DATE:      held_date_in      = acc_ff[31:0];
                  FIELD_TIME:      held_time_in      = acc_ff[15:0];
                  FIELD_AREA:      held_area_in      = acc_ff;
                  FIELD_RESIDENCE: held_signed_in[0] = signed_val;
                  FIELD_AGE:       held_signed_in[1] = signed_val;
                  FIELD_GENDER:    held_signed_in[2] = signed_val;
                  default:         held_date_in      = held_date_ff;
               endcase
            end else begin
               row_bad_in = 1'b1;
            end
            if (field_index_ff >= FIELD_POPULATION) begin
               row_bad_in = 1'b1;
            end else begin
               field_index_in = field_index_ff + 3'd1;
            end
            field_phase_in = PHASE_BLANKS;
            negative_in    = 1'b0;
            acc_in         = '0;
         end else if (is_digit) begin
            field_phase_in = PHASE_DIGITS;
            if (!row_bad_ff) begin
               if (overflow) begin
                  row_bad_in = 1'b1;
               end else begin
                  acc_in = acc_step;
               end
            end
         end else if ((field_phase_ff == PHASE_BLANKS) && is_blank) begin
            field_phase_in = PHASE_BLANKS;
         end else if ((field_phase_ff == PHASE_BLANKS) && (in_byte_ff == CHAR_PLUS)) begin
            field_phase_in = PHASE_SIGN;
         end else if ((field_phase_ff == PHASE_BLANKS) && (in_byte_ff == CHAR_MINUS)) begin
            if (field_index_ff < FIELD_RESIDENCE) begin
               row_bad_in = 1'b1;
            end
            negative_in    = 1'b1;
            field_phase_in = PHASE_SIGN;
         end else begin
            row_bad_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_in            = '0;
      out_in.line_index = line_count_ff + 32'd1;
      if (!header_done_ff) begin
         out_in.status = ((header_pos_ff == HDR_END) && !header_bad_ff) ?
                         STATUS_HEADER_OK : STATUS_HEADER_MISMATCH;
      end else if (row_ok) begin
         out_in.status     = STATUS_ROW_OK;
         out_in.date       = held_date_ff;
         out_in.time_res   = held_time_ff;
         out_in.area       = held_area_ff;
         out_in.residence  = $signed(held_signed_ff[0]);
         out_in.age        = $signed(held_signed_ff[1]);
         out_in.gender     = $signed(held_signed_ff[2]);
         out_in.population = $signed(signed_val);
      end else begin
         out_in.status = STATUS_ROW_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.data_byte;
         in_end_ff  <= req_bus.end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_done_ff  <= 1'b0;
         header_pos_ff   <= '0;
         header_bad_ff   <= 1'b0;
         line_count_ff   <= '0;
         field_index_ff  <= FIELD_DATE;
         field_phase_ff  <= PHASE_BLANKS;
         negative_ff     <= 1'b0;
         acc_ff          <= '0;
         row_bad_ff      <= 1'b0;
         line_started_ff <= 1'b0;
      end else if (process) begin
         header_done_ff  <= header_done_in;
         header_pos_ff   <= header_pos_in;
         header_bad_ff   <= header_bad_in;
         line_count_ff   <= line_count_in;
         field_index_ff  <= field_index_in;
         field_phase_ff  <= field_phase_in;
         negative_ff     <= negative_in;
         acc_ff          <= acc_in;
         row_bad_ff      <= row_bad_in;
         line_started_ff <= line_started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         held_date_ff   <= held_date_in;
         held_time_ff   <= held_time_in;
         held_area_ff   <= held_area_in;
         held_signed_ff <= held_signed_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.status     = out_ff.status;
   assign rsp_bus.date       = out_ff.date;
   assign rsp_bus.time_res   = out_ff.time_res;
   assign rsp_bus.area       = out_ff.area;
   assign rsp_bus.residence  = out_ff.residence;
   assign rsp_bus.age        = out_ff.age;
   assign rsp_bus.gender     = out_ff.gender;
   assign rsp_bus.population = out_ff.population;
   assign rsp_bus.line_index = out_ff.line_index;

   assign fail_beat   = out_valid_ff && (out_ff.status != STATUS_ROW_OK);
   assign values_zero = (out_ff.date == 32'd0) && (out_ff.time_res == 16'd0) &&
                        (out_ff.area == 64'd0) && (out_ff.population == 32'sd0);
   assign count_next  = line_count_ff + 32'd1;
   assign index_ok    = field_index_ff <= FIELD_POPULATION;

`include "csv_fixed_schema_row_parser_assert.svh"

   `CSVP_ASSERT_NOW(a_zero_on_fail, fail_beat, values_zero, "Nonzero value on a failed line")
   `CSVP_ASSERT_NEXT(a_header_sticky, header_done_ff, header_done_ff, "Header acceptance lost")
   `CSVP_ASSERT_NEXT(a_line_count, emit, line_count_ff == $past(count_next), "Line count stuck")
   `CSVP_ASSERT_NOW(a_field_range, header_done_ff, index_ok, "Field index overrun")

endmodule
